// File: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and helpers of the set-associative LRU cache tags.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  localparam int SETS      = 64;
  localparam int WAYS      = 4;
  localparam int ADDR_BITS = 32;

  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NWAY_W = $clog2(WAYS + 1);
  localparam int TAG_W  = ADDR_BITS - 2;

  localparam int OFF_W  = 4;
  localparam int IDXB_W = 3;
  localparam int WAYC_W = 3;
  localparam int CFG_W  = 4;

  localparam logic [OFF_W-1:0]  OFF_MIN = OFF_W'(2);
  localparam logic [OFF_W-1:0]  OFF_MAX = OFF_W'(8);
  localparam logic [IDXB_W-1:0] IDX_MAX = IDXB_W'(6);

  localparam logic [OFF_W-1:0]  OFF_RESET  = OFF_W'(2);
  localparam logic [IDXB_W-1:0] IDXB_RESET = IDXB_W'(0);
  localparam logic [WAYC_W-1:0] WAYC_RESET = WAYC_W'(1);

  typedef enum logic [1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] rank;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic             victim_valid;
    logic             writeback;
    logic [TAG_W-1:0] victim_tag;
    row_t             new_row;
  } lookup_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w]      = '0;
      r[w].rank = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag, valid, dirty and LRU rank controller of a set-associative write-back
// cache, with one metadata RAM row per set.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  ---------------------------------------
//   in       in_valid / in_stall       address, mode
//   out      out_valid / out_stall     hit, fill, victim_valid, writeback,
//                                      victim_address, block_address
//   cfg      cfg_write_enable          cfg_index, cfg_data
//
// The set row is read from the metadata RAM as an item is accepted in ST_IDLE;
// ST_LOOKUP searches the ways, picks the victim and writes the new row back.
// A per-set flag, cleared by reset, makes a set that was never written read
// as its reset contents, so no clearing pass is needed after reset.
// A result waits in the output register while the next item is accepted;
// that item holds in ST_LOOKUP until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tags
  import salc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_enable,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic                 mode,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      hit,
  output logic                      fill,
  output logic                      victim_valid,
  output logic                      writeback,
  output logic [ADDR_BITS-1:0]      victim_address,
  output logic [ADDR_BITS-1:0]      block_address
);

  logic [OFF_W-1:0]  offset_bits;
  logic [IDXB_W-1:0] index_bits;
  logic [WAYC_W-1:0] ways_in_use;

  logic [OFF_W-1:0]  off;
  logic [IDXB_W-1:0] idxb;
  logic [NWAY_W-1:0] nways;

  state_t state;
  state_t state_next;

  logic [ADDR_BITS-1:0] addr_q;
  logic                 mode_q;
  logic [SET_W-1:0]     set_q;
  logic [SETS-1:0]      set_written;

  logic                 in_accept;
  logic                 out_free;
  logic                 complete;
  logic                 rd_en;
  logic                 wr_en;

  logic [ADDR_BITS-1:0] above_in;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_BITS-1:0] above_q;
  logic [TAG_W-1:0]     tag;

  logic [ROW_W-1:0]     ram_rd_data;
  row_t                 row;
  lookup_t              look;
  logic [ADDR_BITS-1:0] vaddr;
  logic [ADDR_BITS-1:0] baddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFF_RESET;
      index_bits  <= IDXB_RESET;
      ways_in_use <= WAYC_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OFF_W-1:0];
        CFG_INDEX_BITS:  index_bits  <= cfg_data[IDXB_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[WAYC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (offset_bits < OFF_MIN) begin
      off = OFF_MIN;
    end else if (offset_bits > OFF_MAX) begin
      off = OFF_MAX;
    end else begin
      off = offset_bits;
    end
    idxb = (index_bits > IDX_MAX) ? IDX_MAX : index_bits;
    priority if (ways_in_use == '0) begin
      nways = NWAY_W'(1);
    end else if (NWAY_W'(ways_in_use) > NWAY_W'(WAYS)) begin
      nways = NWAY_W'(WAYS);
    end else begin
      nways = NWAY_W'(ways_in_use);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    in_stall = 1'b1;
    complete = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_LOOKUP: complete = out_free;
      default: begin
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign rd_en     = in_accept;
  assign wr_en     = complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign above_in = address >> off;
  assign set_mask = SET_W'((7'd1 << idxb) - 7'd1);
  assign set_in   = above_in[SET_W-1:0] & set_mask;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_q <= address;
      mode_q <= mode;
      set_q  <= set_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_written <= '0;
    end else if (wr_en) begin
      set_written[set_q] <= 1'b1;
    end
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_meta_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(set_q),
    .wr_data(look.new_row),
    .rd_en  (rd_en),
    .rd_addr(set_in),
    .rd_data(ram_rd_data)
  );

  assign row     = set_written[set_q] ? row_t'(ram_rd_data) : reset_row();
  assign above_q = addr_q >> off;
  assign tag     = TAG_W'(above_q >> idxb);

  salc_lookup u_lookup (
    .row   (row),
    .tag   (tag),
    .nways (nways),
    .mode  (mode_q),
    .result(look)
  );

  assign vaddr = look.victim_valid
               ? (((ADDR_BITS'(look.victim_tag) << idxb) | ADDR_BITS'(set_q)) << off)
               : '0;
  assign baddr = addr_q & ~((ADDR_BITS'(1) << off) - ADDR_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (complete) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      hit            <= look.hit;
      fill           <= !look.hit;
      victim_valid   <= look.victim_valid;
      writeback      <= look.writeback;
      victim_address <= vaddr;
      block_address  <= baddr;
    end
  end

endmodule

`default_nettype wire

// File: rtl/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// Way search, victim choice and LRU rank update for one set row.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_lookup
  import salc_pkg::*;
(
  input  wire row_t              row,
  input  wire logic [TAG_W-1:0]  tag,
  input  wire logic [NWAY_W-1:0] nways,
  input  wire logic              mode,
  output lookup_t                result
);

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             inval;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] best;
  logic [WAY_W-1:0] way;
  logic [WAY_W-1:0] touched_rank;

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inval     = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    best      = row[0].rank;
    for (int w = 0; w < WAYS; w++) begin
      if (NWAY_W'(w) < nways) begin
        if (!hit_found && row[w].valid && row[w].tag == tag) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!row[w].valid) begin
          inval   = 1'b1;
          inv_way = WAY_W'(w);
        end
        if (w > 0 && row[w].rank > best) begin
          best    = row[w].rank;
          lru_way = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    priority if (hit_found) begin
      way = hit_way;
    end else if (inval) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end
  end

  assign touched_rank = row[way].rank;

  always_comb begin
    result              = '0;
    result.hit          = hit_found;
    result.victim_valid = !hit_found && !inval;
    result.writeback    = !hit_found && !inval && row[way].dirty;
    result.victim_tag   = row[way].tag;
    for (int w = 0; w < WAYS; w++) begin
      result.new_row[w] = row[w];
      if (row[w].rank < touched_rank) begin
        result.new_row[w].rank = row[w].rank + 1'b1;
      end
    end
    result.new_row[way].rank  = '0;
    result.new_row[way].valid = 1'b1;
    result.new_row[way].tag   = tag;
    result.new_row[way].dirty = mode || (hit_found && row[way].dirty);
  end

endmodule

`default_nettype wire
